// ----- rtl/core/ppm_p6_header_parser_core_assert.svh -----
// assertion macros shared by the parser core
// both sample on clock and are disabled while reset is high
`ifndef PPM_P6_HEADER_PARSER_CORE_ASSERT_SVH
`define PPM_P6_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define P6HP_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define P6HP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/p6hp_pkg.sv -----
package p6hp_pkg;

   // field widths
   localparam int DIM_BITS_DEF = 16;
   localparam int BYTE_W       = 8;
   localparam int OUT_DIM_W    = 16;
   localparam int STATUS_W     = 3;
   localparam int LEFT_W       = 34;

   localparam logic [LEFT_W-1:0] LEFT_MAX = '1;

   // header characters
   localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
   localparam logic [BYTE_W-1:0] CHAR_SIX   = 8'h36;
   localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_HEADER = 3'd0,
      ST_DONE   = 3'd1,
      ST_ERROR  = 3'd2,
      ST_PIXEL  = 3'd3,
      ST_IGNORE = 3'd4
   } p6hp_status_type;

   // one input word
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              first_byte;
   } p6hp_req_type;

   // one result word
   typedef struct packed {
      p6hp_status_type      status;
      logic [OUT_DIM_W-1:0] image_width;
      logic [OUT_DIM_W-1:0] image_height;
      logic [BYTE_W-1:0]    pixel_byte;
      logic                 last_pixel;
   } p6hp_rsp_type;

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_ws(input logic [BYTE_W-1:0] c);
      return c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] c);
      return c inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

endpackage

// ----- rtl/core/p6hp_in_stage.sv -----
module p6hp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  p6hp_pkg::p6hp_req_type req_word,
   input  logic                  advance,
   output logic                  word_valid,
   output p6hp_pkg::p6hp_req_type word
);
   import p6hp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         load;
   p6hp_req_type word_ff;

   // register takes a new word when empty or when its word moves on
   assign load      = !valid_ff || advance;
   assign req_stall = valid_ff && !advance;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// ----- rtl/core/p6hp_size_mult.sv -----
module p6hp_size_mult #(
   parameter int DIM_BITS = p6hp_pkg::DIM_BITS_DEF
) (
   input  logic                        clock,
   input  logic [DIM_BITS-1:0]         width_acc,
   input  logic [DIM_BITS-1:0]         height_acc,
   output logic [p6hp_pkg::LEFT_W-1:0] payload_count
);
   import p6hp_pkg::*;

   localparam int TRI_W  = DIM_BITS + 2;
   localparam int PROD_W = TRI_W + DIM_BITS;
   localparam int EXT_W  = (PROD_W > LEFT_W) ? PROD_W : LEFT_W;

   logic [TRI_W-1:0]  triple_width;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   logic [EXT_W-1:0]  prod_ext;

   // 3 * width as shift and add, then one multiply by height
   assign triple_width = {2'b00, width_acc} + {1'b0, width_acc, 1'b0};
   assign prod_in      = PROD_W'(triple_width) * PROD_W'(height_acc);

   // refreshed every cycle; dimensions settle well before the header ends
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // saturate to the counter width
   assign prod_ext      = EXT_W'(prod_ff);
   assign payload_count = (prod_ext > EXT_W'(LEFT_MAX)) ? LEFT_MAX : prod_ext[LEFT_W-1:0];

endmodule

// ----- rtl/core/p6hp_parse_fsm.sv -----
module p6hp_parse_fsm #(
   parameter int DIM_BITS = p6hp_pkg::DIM_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  p6hp_pkg::p6hp_req_type      word,
   input  logic [p6hp_pkg::LEFT_W-1:0] payload_count,
   output logic [DIM_BITS-1:0]         width_acc,
   output logic [DIM_BITS-1:0]         height_acc,
   output p6hp_pkg::p6hp_rsp_type      rsp_word
);
   import p6hp_pkg::*;

   localparam int ACC_W = DIM_BITS + 4;
   localparam int EXT_W = DIM_BITS + OUT_DIM_W;

   typedef enum logic [2:0] {
      PH_MAGIC0  = 3'd0,
      PH_MAGIC1  = 3'd1,
      PH_PREV    = 3'd2,
      PH_WIDTH   = 3'd3,
      PH_HEIGHT  = 3'd4,
      PH_MAXVAL  = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_IDLE    = 3'd7
   } phase_type;

   phase_type           phase_ff, phase_in, phase_cur;
   logic                comment_ff, comment_in, comment_cur;
   logic [BYTE_W-1:0]   prev_ff, prev_in, prev_cur;
   logic [DIM_BITS-1:0] width_ff, width_in, width_cur;
   logic [DIM_BITS-1:0] height_ff, height_in, height_cur;
   logic [LEFT_W-1:0]   left_ff, left_in, left_cur, left_dec;
   p6hp_rsp_type        rsp_ff, rsp_in;

   logic [BYTE_W-1:0]   b;
   logic [BYTE_W-1:0]   digit_diff;
   logic [DIM_BITS-1:0] sel_acc;
   logic [ACC_W-1:0]    next_acc;
   logic                digit_fits;
   logic [EXT_W-1:0]    width_ext;
   logic [EXT_W-1:0]    height_ext;

   // restart view: first byte of a file sees reset state
   always_comb begin
      if (word.first_byte) begin
         phase_cur   = PH_MAGIC0;
         comment_cur = 1'b0;
         prev_cur    = '0;
         width_cur   = '0;
         height_cur  = '0;
         left_cur    = '0;
      end else begin
         phase_cur   = phase_ff;
         comment_cur = comment_ff;
         prev_cur    = prev_ff;
         width_cur   = width_ff;
         height_cur  = height_ff;
         left_cur    = left_ff;
      end
   end

   // decimal accumulate: acc * 10 + digit, overflow shows in the top bits
   assign b          = word.byte_value;
   assign digit_diff = b - CHAR_ZERO;
   assign sel_acc    = (phase_cur == PH_HEIGHT) ? height_cur : width_cur;
   assign next_acc   = {1'b0, sel_acc, 3'b000} + {3'b000, sel_acc, 1'b0}
                       + ACC_W'(digit_diff[3:0]);
   assign digit_fits = is_digit(b) && (next_acc[ACC_W-1:DIM_BITS] == '0);

   assign left_dec = (left_cur != '0) ? left_cur - LEFT_W'(1) : left_cur;

   // next state and result for one byte
   always_comb begin
      phase_in   = phase_cur;
      comment_in = comment_cur;
      prev_in    = prev_cur;
      width_in   = width_cur;
      height_in  = height_cur;
      left_in    = left_cur;
      rsp_in.status     = ST_HEADER;
      rsp_in.pixel_byte = '0;
      rsp_in.last_pixel = 1'b0;

      case (phase_cur)
         PH_MAGIC0: begin
            if (b == CHAR_P) begin
               phase_in = PH_MAGIC1;
            end else begin
               rsp_in.status = ST_ERROR;
               phase_in      = PH_IDLE;
            end
         end
         PH_MAGIC1: begin
            if (b == CHAR_SIX) begin
               phase_in = PH_PREV;
            end else begin
               rsp_in.status = ST_ERROR;
               phase_in      = PH_IDLE;
            end
         end
         PH_PREV: begin
            prev_in  = b;
            phase_in = PH_WIDTH;
         end
         PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
            if (comment_cur) begin
               if (b == CHAR_NL) begin
                  comment_in = 1'b0;
               end
            end else if (is_ws(b)) begin
               // a field ends on the first whitespace after it
               if (!is_ws(prev_cur)) begin
                  if (phase_cur == PH_MAXVAL) begin
                     left_in       = payload_count;
                     rsp_in.status = ST_DONE;
                     phase_in      = (payload_count != '0) ? PH_PAYLOAD : PH_IDLE;
                  end else if (phase_cur == PH_WIDTH) begin
                     phase_in = PH_HEIGHT;
                  end else begin
                     phase_in = PH_MAXVAL;
                  end
               end
            end else if (b == CHAR_HASH) begin
               comment_in = 1'b1;
            end else if (phase_cur != PH_MAXVAL) begin
               if (digit_fits) begin
                  if (phase_cur == PH_WIDTH) begin
                     width_in = next_acc[DIM_BITS-1:0];
                  end else begin
                     height_in = next_acc[DIM_BITS-1:0];
                  end
               end else begin
                  rsp_in.status = ST_ERROR;
                  phase_in      = PH_IDLE;
               end
            end
            prev_in = b;
         end
         PH_PAYLOAD: begin
            rsp_in.status     = ST_PIXEL;
            rsp_in.pixel_byte = b;
            left_in           = left_dec;
            if (left_dec == '0) begin
               rsp_in.last_pixel = 1'b1;
               phase_in          = PH_IDLE;
            end
         end
         default: begin
            rsp_in.status = ST_IGNORE;
         end
      endcase

      width_ext           = EXT_W'(width_in);
      height_ext          = EXT_W'(height_in);
      rsp_in.image_width  = width_ext[OUT_DIM_W-1:0];
      rsp_in.image_height = height_ext[OUT_DIM_W-1:0];
   end

   // parser state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC0;
         comment_ff <= 1'b0;
         prev_ff    <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         left_ff    <= '0;
         rsp_ff     <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         prev_ff    <= prev_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         left_ff    <= left_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign width_acc  = width_ff;
   assign height_acc = height_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ----- rtl/core/ppm_p6_header_parser_core.sv -----
// Binary PPM (P6) header parser with pixel pass-through.
// Request channel: req_valid / req_stall carry one file byte per word in
// req_byte_value; req_first_byte restarts the parser on that byte.
// Response channel: rsp_valid / rsp_stall return exactly one word per
// request word: rsp_status (header, done, error, pixel, ignored), the
// parsed width and height, the pixel byte and a last-pixel mark.
// Path: request accept into the input register, then the parse step into
// the response register.
// Throughput: one word per cycle while rsp_stall is low; the parse
// step is a single registered pass and the payload size multiply runs
// every cycle from the held dimensions, ready before the header can end.
// Reset (synchronous, active high) empties both registers and puts the
// parser at the first magic byte.
// While rsp_stall is high the response word holds, the input register
// keeps one more word, and req_stall rises once that register is full.
// A file that ends early is not detected; the sender must restart it.
`include "ppm_p6_header_parser_core_assert.svh"

module ppm_p6_header_parser_core #(
   parameter int DIM_BITS = p6hp_pkg::DIM_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [p6hp_pkg::BYTE_W-1:0]    req_byte_value,
   input  logic                           req_first_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [p6hp_pkg::STATUS_W-1:0]  rsp_status,
   output logic [p6hp_pkg::OUT_DIM_W-1:0] rsp_image_width,
   output logic [p6hp_pkg::OUT_DIM_W-1:0] rsp_image_height,
   output logic [p6hp_pkg::BYTE_W-1:0]    rsp_pixel_byte,
   output logic                           rsp_last_pixel
);
   import p6hp_pkg::*;

   p6hp_req_type        req_word;
   p6hp_req_type        in_word;
   logic                in_valid;
   logic                advance;
   logic                step;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [DIM_BITS-1:0] width_acc;
   logic [DIM_BITS-1:0] height_acc;
   logic [LEFT_W-1:0]   payload_count;
   p6hp_rsp_type        rsp_word;

   assign req_word.byte_value = req_byte_value;
   assign req_word.first_byte = req_first_byte;

   // input register
   p6hp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .word_valid (in_valid),
      .word       (in_word)
   );

   // response register frees up when empty or when its word is taken
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign step         = in_valid && advance;
   assign rsp_valid_in = advance ? in_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload size from held dimensions
   p6hp_size_mult #(
      .DIM_BITS (DIM_BITS)
   ) u_size_mult (
      .clock         (clock),
      .width_acc     (width_acc),
      .height_acc    (height_acc),
      .payload_count (payload_count)
   );

   // header parser and response register
   p6hp_parse_fsm #(
      .DIM_BITS (DIM_BITS)
   ) u_parse_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .word          (in_word),
      .payload_count (payload_count),
      .width_acc     (width_acc),
      .height_acc    (height_acc),
      .rsp_word      (rsp_word)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_word.status;
   assign rsp_image_width  = rsp_word.image_width;
   assign rsp_image_height = rsp_word.image_height;
   assign rsp_pixel_byte   = rsp_word.pixel_byte;
   assign rsp_last_pixel   = rsp_word.last_pixel;

   // checks
   `P6HP_ASSERT_NEXT(a_step_gives_rsp, step, rsp_valid, "parsed word did not reach the response")
   `P6HP_ASSERT_NEXT(a_restart_status, step && in_word.first_byte,
      rsp_status == ST_HEADER || rsp_status == ST_ERROR, "restart byte gave a wrong status")
   `P6HP_ASSERT_NOW(a_pixel_fields, rsp_valid && rsp_status != ST_PIXEL,
      !rsp_last_pixel && rsp_pixel_byte == '0, "pixel fields set outside a pixel word")

endmodule
